/* hdl/crle_pkg.sv */
// ----------------------------------------------------------------------------
// crle_pkg
// Shared types and constants of the circular list ring engine: operation
// codes, result status codes, sequencer states and the default capacity.
// ----------------------------------------------------------------------------
package crle_pkg;

	// default number of element slots in the ring
	localparam int CAPACITY_DEF = 64;

	// width of one stored element
	localparam int ELEM_W = 32;

	// operation codes carried by func; the two highest codes are no-ops
	typedef enum logic [2:0] {
		FN_INSERT = 3'd0,
		FN_DELETE = 3'd1,
		FN_ROTATE = 3'd2,
		FN_COUNT  = 3'd3,
		FN_READ   = 3'd4,
		FN_CLEAR  = 3'd5
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_RDATA,
		S_FIN
	} seq_state_t;

endpackage

/* hdl/crle_ram.sv */
// ----------------------------------------------------------------------------
// crle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/circular_list_ring_engine.sv */
// ----------------------------------------------------------------------------
// circular_list_ring_engine
// Bounded circular list kept as a ring in one RAM, with a window on one
// element: insert, delete, rotate, count matches, read window and clear.
// ----------------------------------------------------------------------------
// One request is taken at a time. req_stall is high while it is worked on.
// The result then sits in an output register, so the next request can be
// taken while the result waits. Insert, delete, clear and the unused codes
// go straight from acceptance to the finish state. Read and rotate on a
// non-empty list pass through the read-data state for the registered read
// of the element RAM. Count on a non-empty list scans the stored elements,
// then drains the last registered read before it finishes. The scan walks
// one element per cycle, as the single RAM read port allows. While an earlier
// result is still held in the output register, the finished item waits in
// the finish state until that register is free. The RAM needs no clearing
// after reset; only live slots are ever read.
module circular_list_ring_engine #(
	parameter int CAPACITY = crle_pkg::CAPACITY_DEF,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [2:0]                 func,
	input  logic signed [crle_pkg::ELEM_W-1:0] value,
	// response channel
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic signed [crle_pkg::ELEM_W-1:0] window_value,
	output logic [CW-1:0]              match_count,
	output logic [CW-1:0]              list_size,
	output logic [1:0]                 status
);

	import crle_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);
	localparam logic [CW:0] CAP_X = (CW + 1)'(CAPACITY);

	seq_state_t state_q, state_d;

	logic [AW-1:0] wp_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] idx_q;
	logic          pend_q;
	logic          rsp_valid_q;

	func_t                func_q;
	logic [ELEM_W-1:0]    value_q;
	status_t              stat_q;
	logic [ELEM_W-1:0]    wval_q;
	logic [CW-1:0]        matches_q;

	logic [ELEM_W-1:0]    window_value_q;
	logic [CW-1:0]        match_count_q;
	logic [CW-1:0]        list_size_q;
	status_t              status_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ELEM_W-1:0]    ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [ELEM_W-1:0]    ram_rdata;

	func_t         fn;
	logic          accept;
	logic          full;
	logic          empty;
	logic          rsp_free;
	logic [AW-1:0] wp_dec;
	logic [AW-1:0] wp_inc;
	logic [AW-1:0] ptr_inc;
	logic [CW:0]   tail_sum;
	logic [AW-1:0] tail;
	logic [CW-1:0] last_idx;

	// decode and ring address arithmetic
	assign fn       = func_t'(func);
	assign accept   = (state_q == S_IDLE) && req_valid;
	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign wp_dec   = (wp_q == '0) ? LAST_SLOT : wp_q - 1'b1;
	assign wp_inc   = (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
	assign ptr_inc  = (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
	assign tail_sum = {1'b0, CW'(wp_q)} + {1'b0, count_q};
	assign tail     = (tail_sum >= CAP_X) ? AW'(tail_sum - CAP_X) : AW'(tail_sum);
	assign last_idx = count_q - 1'b1;

	// element store
	crle_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and RAM port control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = wp_dec;
		ram_wdata = value;
		ram_raddr = wp_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (fn)
						FN_INSERT: begin
							ram_we  = !full;
							state_d = S_FIN;
						end
						FN_ROTATE, FN_READ: begin
							state_d = empty ? S_FIN : S_RDATA;
						end
						FN_COUNT: begin
							state_d = empty ? S_FIN : S_SCAN;
						end
						default: begin
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_SCAN: begin
				ram_raddr = ptr_q;
				if (idx_q == last_idx) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FIN;
			end
			S_RDATA: begin
				// rotate copies the old window element behind the last one
				if (func_q == FN_ROTATE) begin
					ram_we    = 1'b1;
					ram_waddr = tail;
					ram_wdata = ram_rdata;
				end
				state_d = S_FIN;
			end
			S_FIN: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// list state, scan pointer and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_q <= (state_q == S_SCAN);
			if (accept) begin
				unique case (fn)
					FN_INSERT: begin
						if (!full) begin
							wp_q    <= wp_dec;
							count_q <= count_q + 1'b1;
						end
					end
					FN_DELETE: begin
						if (!empty) begin
							count_q <= last_idx;
							wp_q    <= (last_idx == '0) ? '0 : wp_inc;
						end
					end
					FN_COUNT: begin
						ptr_q <= wp_q;
						idx_q <= '0;
					end
					FN_CLEAR: begin
						count_q <= '0;
						wp_q    <= '0;
					end
					default: begin
					end
				endcase
			end
			// advance the scan one slot per cycle
			if (state_q == S_SCAN) begin
				ptr_q <= ptr_inc;
				idx_q <= idx_q + 1'b1;
			end
			// advance the window after a rotate
			if (state_q == S_RDATA && func_q == FN_ROTATE) begin
				wp_q <= wp_inc;
			end
			// hold the result until taken
			if (state_q == S_FIN && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// item payload, match counter and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= fn;
			value_q   <= value;
			wval_q    <= '0;
			matches_q <= '0;
			stat_q    <= ST_OK;
			unique case (fn)
				FN_INSERT: begin
					if (full) begin
						stat_q <= ST_FULL;
					end
				end
				FN_DELETE, FN_ROTATE, FN_COUNT, FN_READ: begin
					if (empty) begin
						stat_q <= ST_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end
		// compare one element a cycle against the requested value
		if (pend_q && ram_rdata == value_q) begin
			matches_q <= matches_q + 1'b1;
		end
		if (state_q == S_RDATA && func_q == FN_READ) begin
			wval_q <= ram_rdata;
		end
		if (state_q == S_FIN && rsp_free) begin
			window_value_q <= wval_q;
			match_count_q  <= matches_q;
			list_size_q    <= count_q;
			status_q       <= stat_q;
		end
	end

	assign req_stall    = (state_q != S_IDLE);
	assign rsp_valid    = rsp_valid_q;
	assign window_value = window_value_q;
	assign match_count  = match_count_q;
	assign list_size    = list_size_q;
	assign status       = status_q;

endmodule

/* hdl/crle_checker.sv */
// ----------------------------------------------------------------------------
// crle_checker
// Port-level checks of the circular list ring engine, bound to the top level.
// ----------------------------------------------------------------------------
module crle_checker #(
	parameter int CAPACITY = crle_pkg::CAPACITY_DEF,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_stall,
	input logic signed [crle_pkg::ELEM_W-1:0] window_value,
	input logic [CW-1:0]              match_count,
	input logic [CW-1:0]              list_size,
	input logic [1:0]                 status
);

	import crle_pkg::*;

	// hold a stalled result unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(window_value)
			&& $stable(match_count) && $stable(list_size) && $stable(status))
		else $error("stalled result changed");

	// a refused insert only happens on a full list
	a_full_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> list_size == CW'(CAPACITY))
		else $error("full status with list not full");

	// an empty status reports nothing stored and nothing found
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |->
			list_size == '0 && match_count == '0 && window_value == '0)
		else $error("empty status with non-zero fields");

	// size never exceeds capacity
	a_size_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> list_size <= CW'(CAPACITY))
		else $error("list size above capacity");

	// matches never exceed the stored elements
	a_match_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> match_count <= list_size)
		else $error("match count above list size");

endmodule

bind circular_list_ring_engine crle_checker #(
	.CAPACITY(CAPACITY)
) u_crle_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.window_value(window_value),
	.match_count (match_count),
	.list_size   (list_size),
	.status      (status)
);

/* tb/tb_circular_list_ring_engine.sv */
// ----------------------------------------------------------------------------
// tb_circular_list_ring_engine
// Self-checking bench for the circular list ring engine. A behavioural ring
// predicts every result as each item is accepted, and the response monitor
// compares each result field by field. It runs directed, full-list,
// back-pressure and random phases with idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_circular_list_ring_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import crle_pkg::*;

	localparam int RING_SLOTS = CAPACITY_DEF;
	localparam int SLOT_W     = $clog2(RING_SLOTS);
	localparam int CNT_W      = $clog2(RING_SLOTS + 1);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_LEN    = 400;
	localparam int DRAIN_WAIT  = 80;
	localparam int MAX_REPORTS = 10;

	// func codes with no operation behind them
	localparam logic [2:0] FN_SPARE_A = 3'd6;
	localparam logic [2:0] FN_SPARE_B = 3'd7;

	typedef struct packed {
		logic [ELEM_W-1:0] w_value;
		logic [CNT_W-1:0]  n_match;
		logic [CNT_W-1:0]  n_size;
		status_t           st;
	} ring_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [2:0] func = '0;
	logic signed [ELEM_W-1:0] value = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic signed [ELEM_W-1:0] window_value;
	logic [CNT_W-1:0] match_count;
	logic [CNT_W-1:0] list_size;
	logic [1:0] status;

	// predicted ring contents, window and fill level
	logic [ELEM_W-1:0] ring_store [RING_SLOTS];
	logic [SLOT_W-1:0] window_slot = '0;
	logic [CNT_W-1:0]  live_count = '0;

	ring_result_t ring_results_q [$];
	logic [ELEM_W-1:0] value_pool [6];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int mismatches = 0;
	int results_seen = 0;
	int cycle_count = 0;

	circular_list_ring_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.func         (func),
		.value        (value),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.window_value (window_value),
		.match_count  (match_count),
		.list_size    (list_size),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the predicted ring by one item and return its result
	function automatic ring_result_t predict_ring(input logic [2:0] op,
			input logic [ELEM_W-1:0] operand);
		ring_result_t r;
		logic [SLOT_W-1:0] slot;
		int i;
		r = '0;
		r.st = ST_OK;
		case (op)
		FN_INSERT: begin
			if (live_count == RING_SLOTS) begin
				r.st = ST_FULL;
			end else begin
				window_slot = window_slot - 1'b1;
				ring_store[window_slot] = operand;
				live_count = live_count + 1'b1;
			end
		end
		FN_DELETE: begin
			if (live_count == 0) begin
				r.st = ST_EMPTY;
			end else begin
				live_count = live_count - 1'b1;
				window_slot = (live_count == 0) ? '0 : window_slot + 1'b1;
			end
		end
		FN_ROTATE: begin
			if (live_count == 0) begin
				r.st = ST_EMPTY;
			end else begin
				// old window element moves behind the last one
				slot = window_slot + SLOT_W'(live_count);
				ring_store[slot] = ring_store[window_slot];
				window_slot = window_slot + 1'b1;
			end
		end
		FN_COUNT: begin
			if (live_count == 0) begin
				r.st = ST_EMPTY;
			end else begin
				for (i = 0; i < live_count; i++) begin
					slot = window_slot + SLOT_W'(i);
					if (ring_store[slot] == operand)
						r.n_match = r.n_match + 1'b1;
				end
			end
		end
		FN_READ: begin
			if (live_count == 0)
				r.st = ST_EMPTY;
			else
				r.w_value = ring_store[window_slot];
		end
		FN_CLEAR: begin
			live_count = '0;
			window_slot = '0;
		end
		default: begin
		end
		endcase
		r.n_size = live_count;
		return r;
	endfunction

	task automatic flag_mismatch(input string field_name, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch on %s at result %0d: expected %0h, got %0h",
				field_name, results_seen, want, got);
	endtask

	// offer one item, wait for it to be taken, then predict its result
	task automatic send_item(input logic [2:0] op, input logic [ELEM_W-1:0] operand);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		func <= op;
		value <= operand;
		do
			@(posedge clk);
		while (req_stall);
		ring_results_q.push_back(predict_ring(op, operand));
	endtask

	// drop valid and hold until every predicted result has come back
	task automatic wait_for_results();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (ring_results_q.size() != 0);
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		send_idle_pct <= sender_pct;
		recv_idle_pct <= receiver_pct;
	endtask

	// empty-list refusals, spare codes, field extremes and window movement
	task automatic test_empty_and_extremes();
		send_item(FN_READ, 32'd0);
		send_item(FN_DELETE, 32'd0);
		send_item(FN_ROTATE, 32'd0);
		send_item(FN_COUNT, 32'd0);
		send_item(FN_SPARE_A, 32'hFFFF_FFFF);
		send_item(FN_SPARE_B, 32'h8000_0000);
		send_item(FN_INSERT, 32'h7FFF_FFFF);
		send_item(FN_INSERT, 32'h8000_0000);
		send_item(FN_INSERT, 32'h0000_0000);
		send_item(FN_INSERT, 32'hFFFF_FFFF);
		send_item(FN_READ, 32'd0);
		send_item(FN_COUNT, 32'h8000_0000);
		send_item(FN_ROTATE, 32'd0);
		send_item(FN_READ, 32'd0);
		send_item(FN_ROTATE, 32'd0);
		send_item(FN_ROTATE, 32'd0);
		send_item(FN_READ, 32'd0);
		send_item(FN_DELETE, 32'd0);
		send_item(FN_COUNT, 32'h7FFF_FFFF);
		send_item(FN_CLEAR, 32'd0);
		send_item(FN_READ, 32'd0);
		send_item(FN_INSERT, 32'd5);
		send_item(FN_DELETE, 32'd0);
		send_item(FN_READ, 32'd0);
	endtask

	// fill to capacity, refuse the next insert, count a full ring
	task automatic test_full_list();
		logic [ELEM_W-1:0] fill_value;
		int k;
		fill_value = $urandom;
		send_item(FN_CLEAR, 32'd0);
		for (k = 0; k < RING_SLOTS; k++)
			send_item(FN_INSERT, fill_value);
		send_item(FN_INSERT, $urandom);
		send_item(FN_COUNT, fill_value);
		send_item(FN_ROTATE, 32'd0);
		send_item(FN_READ, 32'd0);
		send_item(FN_COUNT, ~fill_value);
		send_item(FN_DELETE, 32'd0);
		send_item(FN_INSERT, ~fill_value);
		send_item(FN_INSERT, fill_value);
		send_item(FN_COUNT, ~fill_value);
		send_item(FN_CLEAR, 32'd0);
	endtask

	// hold off the receiver while items keep coming, then pause the sender
	task automatic test_backpressure();
		int k;
		set_idling(0, recv_idle_pct);
		hold_requests <= hold_requests + 1;
		for (k = 0; k < 24; k++)
			send_item((k % 6 == 5) ? FN_COUNT : FN_INSERT, $urandom);
		wait_for_results();
		set_idling(67, 27);
	endtask

	// random walk over the list size with repeated values for matches
	task automatic test_random_mix(input int n_items);
		int k;
		int grow_pct;
		int roll;
		logic [2:0] op;
		logic [ELEM_W-1:0] operand;
		grow_pct = 50;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		value_pool[4] = $urandom;
		value_pool[5] = $urandom;
		for (k = 0; k < n_items; k++) begin
			// change the drift of the size now and then
			if (k % 150 == 0) begin
				case ($urandom_range(2))
				0: grow_pct = 15;
				1: grow_pct = 50;
				default: grow_pct = 90;
				endcase
			end
			roll = $urandom_range(99);
			if (roll < 60)
				op = ($urandom_range(99) < grow_pct) ? FN_INSERT : FN_DELETE;
			else if (roll < 72)
				op = FN_ROTATE;
			else if (roll < 84)
				op = FN_COUNT;
			else if (roll < 96)
				op = FN_READ;
			else if (roll < 97)
				op = FN_CLEAR;
			else
				op = $urandom_range(1) ? FN_SPARE_A : FN_SPARE_B;
			if ($urandom_range(99) < 60)
				operand = value_pool[$urandom_range(5)];
			else
				operand = $urandom;
			send_item(op, operand);
		end
	endtask

	// receiver stall: long hold when asked, random otherwise
	always @(posedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_LEN;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// compare each taken result with the oldest prediction
	always @(posedge clk) begin
		ring_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (ring_results_q.size() == 0) begin
				flag_mismatch("unexpected result, list_size", 32'd0, 32'(list_size));
			end else begin
				want = ring_results_q.pop_front();
				if (window_value !== want.w_value)
					flag_mismatch("window_value", want.w_value, window_value);
				if (match_count !== want.n_match)
					flag_mismatch("match_count", 32'(want.n_match), 32'(match_count));
				if (list_size !== want.n_size)
					flag_mismatch("list_size", 32'(want.n_size), 32'(list_size));
				if (status !== want.st)
					flag_mismatch("status", 32'(want.st), 32'(status));
			end
			results_seen++;
		end
	end

	// end the run if it hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[circular_list_ring_engine] ERROR");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(27, 67);
		test_empty_and_extremes();
		test_full_list();
		test_random_mix(500);
		test_backpressure();
		test_random_mix(500);
		set_idling(0, 0);
		test_random_mix(500);
		wait_for_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && ring_results_q.size() == 0)
			$display("[circular_list_ring_engine] OK");
		else
			$display("[circular_list_ring_engine] ERROR");
		$finish;
	end

endmodule
